### hdl/anisotropic_exponential_variogram_unit_assert.svh
// Assertion macros for the anisotropic exponential variogram unit.
`ifndef ANISOTROPIC_EXPONENTIAL_VARIOGRAM_UNIT_ASSERT_SVH
`define ANISOTROPIC_EXPONENTIAL_VARIOGRAM_UNIT_ASSERT_SVH
`ifndef SYNTH
`define AEV_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("aev: implication check failed");
`define AEV_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("aev: next-cycle check failed");
`define AEV_ASSERT_RST(lbl, ck, rs, cons) \
  lbl: assert property (@(posedge ck) (rs) |=> (cons)) \
    else $error("aev: reset check failed");
`else
`define AEV_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define AEV_ASSERT_NXT(lbl, ck, rs, ante, cons)
`define AEV_ASSERT_RST(lbl, ck, rs, cons)
`endif
`endif

### hdl/aev_pkg.sv
// Shared constants, types and exp ROM tables for the variogram unit.
`default_nettype none
package aev_pkg;

  localparam int EXP_TABLE_BITS = 8;
  localparam int LO_BITS        = 16 - EXP_TABLE_BITS;
  localparam int FRAC_ENTRIES   = 1 << EXP_TABLE_BITS;
  localparam int INT_ENTRIES    = 32;
  localparam int R30_W          = LO_BITS + 14;
  localparam int SQH_W          = 2 * R30_W - 31;

  localparam int H_W            = 21;
  localparam int RAD_W          = 2 * H_W;
  localparam int REM_W          = H_W + 2;
  localparam int SQRT_STAGES    = 7;
  localparam int SQRT_PER_STAGE = 3;

  localparam logic [30:0] ONE30  = 31'h4000_0000;
  localparam logic [61:0] HALF62 = 62'h2000_0000;

  typedef enum logic [2:0] {
    REG_SILL     = 3'd0,
    REG_INV_X    = 3'd1,
    REG_INV_Y    = 3'd2,
    REG_INV_Z    = 3'd3,
    REG_COS      = 3'd4,
    REG_SIN      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [H_W-1:0]   root;
    logic             sat;
  } sq_t;

  typedef logic [30:0] frac_rom_t [FRAC_ENTRIES];
  typedef logic [30:0] int_rom_t  [INT_ENTRIES];

  // Alternating series of exp(-x) through the x^14 term, x in Q0.30, clamped to [0, 1.0]
  function automatic logic [30:0] taylor_exp_neg(input logic [63:0] x);
    logic signed [63:0] sum;
    logic        [63:0] term;
    sum  = 64'(ONE30);
    term = 64'(ONE30);
    for (int i = 1; i <= 14; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      if ((i % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(64'(ONE30))) sum = $signed(64'(ONE30));
    return sum[30:0];
  endfunction

  function automatic frac_rom_t build_frac_rom();
    frac_rom_t t;
    for (int j = 0; j < FRAC_ENTRIES; j++) begin
      t[j] = taylor_exp_neg(64'(j) << (30 - EXP_TABLE_BITS));
    end
    return t;
  endfunction

  function automatic int_rom_t build_int_rom();
    int_rom_t    t;
    logic [63:0] e1;
    logic [63:0] acc;
    e1   = 64'(taylor_exp_neg(64'(ONE30)));
    t[0] = ONE30;
    for (int k = 1; k < INT_ENTRIES; k++) begin
      acc  = (64'(t[k-1]) * e1 + 64'(HALF62)) >> 30;
      t[k] = acc[30:0];
    end
    return t;
  endfunction

  localparam frac_rom_t FRAC_ROM = build_frac_rom();
  localparam int_rom_t  INT_ROM  = build_int_rom();

endpackage
`default_nettype wire

### hdl/anisotropic_exponential_variogram_unit.sv
// Top level: pipelined anisotropic exponential variogram, one pair per cycle unless gamma is held.
//
//  channel  handshake                 payload
//  -------  ------------------------  ----------------------------------------
//  input    in_valid / in_ready       sample_x/y/z, target_x/y/z (Q16.16)
//  output   out_valid / out_ready     gamma (Q16.16)
//  config   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// 21 register stages; one item enters per cycle unless gamma is held and the pipe is full.
// Depth is set by the integer square root (7 stages of 3 bits each) and the
// chain of four multiplies in the exp and sill product.
// Each stage holds its item when the next stage is full and stalled, so
// bubbles are squeezed out and the input keeps flowing while gamma waits, until the pipe is full.
// Synchronous reset clears all valid bits and loads the register defaults.
// cfg_ready is always high; write registers only while the pipe is empty,
// since each stage reads them as the item passes.
`default_nettype none
`include "anisotropic_exponential_variogram_unit_assert.svh"
module anisotropic_exponential_variogram_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [31:0] sample_x,
  input  wire logic signed [31:0] sample_y,
  input  wire logic signed [31:0] sample_z,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] target_z,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic        [31:0] gamma,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire aev_pkg::cfg_reg_t  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  import aev_pkg::*;

  localparam int NST      = 21;
  localparam int SQ_FIRST = 7;
  localparam int EXP_A    = SQ_FIRST + SQRT_STAGES;

  // configuration registers
  logic        [31:0] sill;
  logic        [31:0] inv_range_x;
  logic        [31:0] inv_range_y;
  logic        [31:0] inv_range_z;
  logic signed [15:0] cos_angle;
  logic signed [15:0] sin_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sill        <= 32'd65536;
      inv_range_x <= 32'd65536;
      inv_range_y <= 32'd65536;
      inv_range_z <= 32'd65536;
      cos_angle   <= 16'sd16384;
      sin_angle   <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SILL:  sill        <= cfg_data;
        REG_INV_X: inv_range_x <= cfg_data;
        REG_INV_Y: inv_range_y <= cfg_data;
        REG_INV_Z: inv_range_z <= cfg_data;
        REG_COS:   cos_angle   <= cfg_data[15:0];
        REG_SIN:   sin_angle   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  // stage 0: coordinate differences, exact in 33 bits
  logic signed [32:0] dx0, dy0, dz0;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx0 <= 33'(sample_x) - 33'(target_x);
      dy0 <= 33'(sample_y) - 33'(target_y);
      dz0 <= 33'(sample_z) - 33'(target_z);
    end
  end

  // stage 1: rotation products
  logic signed [48:0] pxc1, pys1, pxs1, pyc1;
  logic signed [32:0] dz1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pxc1 <= 49'(dx0) * 49'(cos_angle);
      pys1 <= 49'(dy0) * 49'(sin_angle);
      pxs1 <= 49'(dx0) * 49'(sin_angle);
      pyc1 <= 49'(dy0) * 49'(cos_angle);
      dz1  <= dz0;
    end
  end

  // stage 2: rotated magnitudes, rounded back to Q16.16
  logic signed [49:0] rx_s, ry_s;
  logic        [49:0] rx_m, ry_m;
  logic        [32:0] az_m;
  logic        [35:0] ax2, ay2, az2;
  always_comb begin
    rx_s = 50'(pxc1) - 50'(pys1);
    ry_s = 50'(pxs1) + 50'(pyc1);
    rx_m = rx_s[49] ? 50'(-rx_s) : 50'(rx_s);
    ry_m = ry_s[49] ? 50'(-ry_s) : 50'(ry_s);
    az_m = dz1[32] ? 33'(-dz1) : 33'(dz1);
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ax2 <= 36'((rx_m + 50'd8192) >> 14);
      ay2 <= 36'((ry_m + 50'd8192) >> 14);
      az2 <= 36'(az_m);
    end
  end

  // stage 3: range scaling as two 18-bit partial products per axis
  logic [49:0] xlo3, xhi3, ylo3, yhi3, zlo3, zhi3;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      xlo3 <= 50'(ax2[17:0])  * 50'(inv_range_x);
      xhi3 <= 50'(ax2[35:18]) * 50'(inv_range_x);
      ylo3 <= 50'(ay2[17:0])  * 50'(inv_range_y);
      yhi3 <= 50'(ay2[35:18]) * 50'(inv_range_y);
      zlo3 <= 50'(az2[17:0])  * 50'(inv_range_z);
      zhi3 <= 50'(az2[35:18]) * 50'(inv_range_z);
    end
  end

  // stage 4: combine partials, flag axes at or beyond 32.0, round
  logic [67:0] px, py, pz;
  logic [21:0] ux4, uy4, uz4;
  logic        sat4;
  always_comb begin
    px = (68'(xhi3) << 18) + 68'(xlo3);
    py = (68'(yhi3) << 18) + 68'(ylo3);
    pz = (68'(zhi3) << 18) + 68'(zlo3);
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ux4  <= 22'((38'(px[36:0]) + 38'd32768) >> 16);
      uy4  <= 22'((38'(py[36:0]) + 38'd32768) >> 16);
      uz4  <= 22'((38'(pz[36:0]) + 38'd32768) >> 16);
      sat4 <= (|px[67:37]) || (|py[67:37]) || (|pz[67:37]);
    end
  end

  // stage 5: squares
  logic [43:0] qx5, qy5, qz5;
  logic        sat5;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      qx5  <= 44'(ux4) * 44'(ux4);
      qy5  <= 44'(uy4) * 44'(uy4);
      qz5  <= 44'(uz4) * 44'(uz4);
      sat5 <= sat4;
    end
  end

  // stage 6: sum of squares; h at or beyond 32.0 saturates
  logic [45:0]      sum6;
  logic [RAD_W-1:0] rad6;
  logic             sat6;
  assign sum6 = 46'(qx5) + 46'(qy5) + 46'(qz5);
  always_ff @(posedge clk) begin
    if (en[6]) begin
      rad6 <= sum6[RAD_W-1:0];
      sat6 <= sat5 || (|sum6[45:RAD_W]);
    end
  end

  // stages 7..13: digit-by-digit square root, one result bit per step
  function automatic sq_t sq_step(input sq_t a);
    sq_t              b;
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    b     = a;
    r     = {a.rem, a.rad[RAD_W-1 -: 2]};
    t     = {2'b00, a.root, 2'b01};
    b.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (r >= t) begin
      b.rem  = REM_W'(r - t);
      b.root = {a.root[H_W-2:0], 1'b1};
    end else begin
      b.rem  = r[REM_W-1:0];
      b.root = {a.root[H_W-2:0], 1'b0};
    end
    return b;
  endfunction

  sq_t sq_pipe [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    sq_t src;
    sq_t res;
    if (s == 0) begin : g_head
      assign src = '{rad: rad6, rem: '0, root: '0, sat: sat6};
    end else begin : g_body
      assign src = sq_pipe[s-1];
    end
    always_comb begin
      res = src;
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
        res = sq_step(res);
      end
    end
    always_ff @(posedge clk) begin
      if (en[SQ_FIRST+s]) sq_pipe[s] <= res;
    end
  end

  // stage 14: split h, read ROMs, square the residual for the polynomial
  logic [H_W-1:0]            h13;
  logic [R30_W-1:0]          r30_c;
  logic [2*R30_W-1:0]        r30_sq;
  logic [30:0]               it14, ft14;
  logic [R30_W-1:0]          r30_14;
  logic [SQH_W-1:0]          sqh14;
  logic                      sat14;
  assign h13    = sq_pipe[SQRT_STAGES-1].root;
  assign r30_c  = {h13[LO_BITS-1:0], 14'b0};
  assign r30_sq = (2*R30_W)'(r30_c) * (2*R30_W)'(r30_c);
  always_ff @(posedge clk) begin
    if (en[EXP_A]) begin
      it14   <= INT_ROM[h13[20:16]];
      ft14   <= FRAC_ROM[h13[15:LO_BITS]];
      r30_14 <= r30_c;
      sqh14  <= r30_sq[2*R30_W-1:31];
      sat14  <= sq_pipe[SQRT_STAGES-1].sat;
    end
  end

  // stage 15: integer times fraction table, residual polynomial
  logic [61:0] m1_15;
  logic [30:0] poly15;
  logic        sat15;
  always_ff @(posedge clk) begin
    if (en[EXP_A+1]) begin
      m1_15  <= 62'(it14) * 62'(ft14);
      poly15 <= ONE30 - 31'(r30_14) + 31'(sqh14);
      sat15  <= sat14;
    end
  end

  // stage 16: round table product
  logic [30:0] a16, poly16;
  logic        sat16;
  always_ff @(posedge clk) begin
    if (en[EXP_A+2]) begin
      a16    <= 31'((m1_15 + HALF62) >> 30);
      poly16 <= poly15;
      sat16  <= sat15;
    end
  end

  // stage 17: apply polynomial
  logic [61:0] m2_17;
  logic        sat17;
  always_ff @(posedge clk) begin
    if (en[EXP_A+3]) begin
      m2_17 <= 62'(a16) * 62'(poly16);
      sat17 <= sat16;
    end
  end

  // stage 18: round exp(-h), clamp to 1.0, form 1 - exp(-h)
  logic [31:0] e18;
  logic [30:0] e_cl;
  logic [30:0] om18;
  logic        sat18;
  assign e18  = 32'((m2_17 + HALF62) >> 30);
  assign e_cl = (e18 > 32'(ONE30)) ? ONE30 : e18[30:0];
  always_ff @(posedge clk) begin
    if (en[EXP_A+4]) begin
      om18  <= ONE30 - e_cl;
      sat18 <= sat17;
    end
  end

  // stage 19: sill product
  logic [62:0] g19;
  logic        sat19;
  always_ff @(posedge clk) begin
    if (en[EXP_A+5]) begin
      g19   <= 63'(sill) * 63'(om18);
      sat19 <= sat18;
    end
  end

  // stage 20: round, clamp to sill, substitute sill on saturation
  logic [32:0] gr;
  assign gr = 33'((g19 + 63'(HALF62)) >> 30);
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      if (sat19 || (gr > 33'(sill))) gamma <= sill;
      else gamma <= gr[31:0];
    end
  end

  `AEV_ASSERT_RST(a_reset_empty, clk, rst, !out_valid)
  `AEV_ASSERT_IMP(a_gamma_le_sill, clk, rst, out_valid, gamma <= sill)
  `AEV_ASSERT_NXT(a_sat_gives_sill, clk, rst, v[NST-2] && sat19 && en[NST-1], gamma == sill)
  `AEV_ASSERT_NXT(a_accept_enters, clk, rst, in_valid && in_ready, v[0])

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the anisotropic exponential variogram unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aev_pkg::*;

  localparam int PIPE_LAT = 21;

  typedef struct {
    logic [31:0] sx, sy, sz, tx, ty, tz;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] sample_x = '0, sample_y = '0, sample_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] gamma;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_SILL;
  logic [31:0] cfg_data = '0;

  anisotropic_exponential_variogram_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .out_valid(out_valid), .out_ready(out_ready), .gamma(gamma),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [31:0] m_sill, m_inv_x, m_inv_y, m_inv_z;
  logic signed [15:0] m_cos, m_sin;

  // Exp ROMs in Q0.30, rebuilt here independently of the package.
  logic [63:0] frac_exp [256];
  logic [63:0] int_exp [32];

  pair_t pending_pairs[$];
  logic [31:0] expected_gamma[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int checked = 0;
  int sat_seen = 0;
  int zero_seen = 0;

  function automatic logic [63:0] series_exp_neg(logic [63:0] x);
    logic signed [63:0] acc;
    logic [63:0] t;
    acc = 64'sd1 <<< 30;
    t = 64'd1 << 30;
    for (int i = 1; i <= 14; i++) begin
      t = ((t * x) >> 30) / i;
      if (i % 2) acc -= $signed(t);
      else acc += $signed(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return acc;
  endfunction

  function automatic logic [63:0] round30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale one axis distance; return 0 when it reaches the saturation limit.
  function automatic bit scale_ok(logic [63:0] a, logic [31:0] inv, output logic [63:0] u);
    u = 0;
    if (inv != 0 && a > ((64'd1 << 37) - 1) / inv) return 0;
    u = (a * inv + (64'd1 << 15)) >> 16;
    return 1;
  endfunction

  function automatic logic [31:0] variogram(pair_t p);
    logic signed [63:0] dx, dy, dz, rx, ry;
    logic [63:0] ax, ay, az, ux, uy, uz, h, f, r30, poly, e, g;
    dx = $signed(p.sx) - $signed(p.tx);
    dy = $signed(p.sy) - $signed(p.ty);
    dz = $signed(p.sz) - $signed(p.tz);
    rx = dx * m_cos - dy * m_sin;
    ry = dx * m_sin + dy * m_cos;
    ax = ((rx < 0 ? -rx : rx) + (64'd1 << 13)) >> 14;
    ay = ((ry < 0 ? -ry : ry) + (64'd1 << 13)) >> 14;
    az = dz < 0 ? -dz : dz;
    if (!scale_ok(ax, m_inv_x, ux) || !scale_ok(ay, m_inv_y, uy) ||
        !scale_ok(az, m_inv_z, uz)) return m_sill;
    h = int_sqrt(ux * ux + uy * uy + uz * uz);
    if (h >= (64'd1 << 21)) return m_sill;
    f = h & 64'hFFFF;
    r30 = (f & 64'hFF) << 14;
    poly = (64'd1 << 30) - r30 + ((r30 * r30) >> 31);
    e = round30(round30(int_exp[h[20:16]], frac_exp[f >> 8]), poly);
    if (e > (64'd1 << 30)) e = 64'd1 << 30;
    g = (64'(m_sill) * ((64'd1 << 30) - e) + (64'd1 << 29)) >> 30;
    if (g > m_sill) g = m_sill;
    return g[31:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Append a pair to the tail of the pending queue.
  task automatic queue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Driver: present queued pairs, advance on acceptance, idle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          expected_gamma.insert(expected_gamma.size(),
                                variogram('{sample_x, sample_y, sample_z,
                                            target_x, target_y, target_z}));
        end
        if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_valid <= 1'b1;
          sample_x <= p.sx; sample_y <= p.sy; sample_z <= p.sz;
          target_x <= p.tx; target_y <= p.ty; target_z <= p.tz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted gamma against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_gamma.size() == 0) begin
          report_mismatch($sformatf("unexpected gamma %h", gamma));
        end else begin
          logic [31:0] want;
          want = expected_gamma.pop_front();
          checked++;
          if (want == m_sill) sat_seen++;
          if (want == 0) zero_seen++;
          if (gamma !== want) begin
            report_mismatch($sformatf("gamma got %h want %h", gamma, want));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Write one register; drop valid after each write.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SILL:  m_sill = val;
      REG_INV_X: m_inv_x = val;
      REG_INV_Y: m_inv_y = val;
      REG_INV_Z: m_inv_z = val;
      REG_COS:   m_cos = val[15:0];
      REG_SIN:   m_sin = val[15:0];
      default: ;
    endcase
  endtask

  // Hold until the pipe drains and every prediction is checked.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_gamma.size() > 0)
      @(negedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic pair_t pair_of(logic [31:0] a, b, c, d, e, f);
    pair_t p;
    p.sx = a; p.sy = b; p.sz = c; p.tx = d; p.ty = e; p.tz = f;
    return p;
  endfunction

  // Random pair; mostly short distances so exp is exercised, some far.
  function automatic pair_t random_pair();
    pair_t p;
    int spread;
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    case ($urandom_range(9))
      0, 1: spread = 32;
      2: spread = 0;
      default: spread = $urandom_range(20);
    endcase
    if (spread == 32) begin
      p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
    end else begin
      p.sx = p.tx + (($urandom & ((64'd1 << spread) - 1)) - (64'd1 << spread) / 2);
      p.sy = p.ty + (($urandom & ((64'd1 << spread) - 1)) - (64'd1 << spread) / 2);
      p.sz = p.tz + (($urandom & ((64'd1 << spread) - 1)) - (64'd1 << spread) / 2);
    end
    return p;
  endfunction

  task automatic random_config();
    write_reg(REG_SILL, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    write_reg(REG_INV_X, $urandom_range(5) == 0 ? 0 : $urandom_range(1 << 18));
    write_reg(REG_INV_Y, $urandom_range(5) == 0 ? 0 : $urandom_range(1 << 18));
    write_reg(REG_INV_Z, $urandom_range(5) == 0 ? 0 : $urandom_range(1 << 18));
    write_reg(REG_COS, 32'($signed(16'($urandom_range(32768) - 16384))));
    write_reg(REG_SIN, 32'($signed(16'($urandom_range(32768) - 16384))));
  endtask

  initial begin
    int pidle [4];
    int pstall [4];
    pidle = '{0, 64, 0, 12};
    pstall = '{0, 0, 64, 12};
    frac_exp[0] = 0;
    for (int j = 0; j < 256; j++) frac_exp[j] = series_exp_neg(64'(j) << 22);
    int_exp[0] = 64'd1 << 30;
    for (int k = 1; k < 32; k++) int_exp[k] = round30(int_exp[k-1], series_exp_neg(64'd1 << 30));
    m_sill = 32'h10000; m_inv_x = 32'h10000; m_inv_y = 32'h10000; m_inv_z = 32'h10000;
    m_cos = 16384; m_sin = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero distance, extremes, saturation, unit steps under reset config.
    queue_pair(pair_of(0, 0, 0, 0, 0, 0));
    queue_pair(pair_of(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h80000000, 32'h80000000));
    queue_pair(pair_of(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0));
    queue_pair(pair_of(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
    queue_pair(pair_of(32'h10000, 0, 0, 0, 0, 0));
    queue_pair(pair_of(0, 32'h10000, 0, 0, 0, 0));
    queue_pair(pair_of(0, 0, 32'h10000, 0, 0, 0));
    queue_pair(pair_of(32'h1F_FFFF, 0, 0, 0, 0, 0));
    queue_pair(pair_of(32'h20_0000, 0, 0, 0, 0, 0));
    queue_pair(pair_of(32'h12_3456, 32'h0A_BCDE, 32'h01_FFFF, 0, 0, 0));
    drain();
    // Directed: extreme registers, zero ranges, non-unit rotation.
    write_reg(REG_SILL, 32'hFFFFFFFF);
    write_reg(REG_INV_X, 0);
    write_reg(REG_INV_Y, 32'hFFFFFFFF);
    write_reg(REG_INV_Z, 0);
    write_reg(REG_COS, 32'hFFFFC000);
    write_reg(REG_SIN, 32'h4000);
    queue_pair(pair_of(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000));
    queue_pair(pair_of(32'h1, 0, 0, 0, 0, 0));
    queue_pair(pair_of(0, 32'h1, 0, 0, 0, 0));
    queue_pair(pair_of(0, 0, 0, 0, 0, 0));
    queue_pair(pair_of(32'h100, 32'h80, 32'h5555, 0, 0, 0));
    drain();
    write_reg(REG_SILL, 0);
    write_reg(REG_COS, 32'h3000);
    write_reg(REG_SIN, 32'hFFFFD000);
    write_reg(REG_INV_Y, 32'h1);
    queue_pair(pair_of(32'h3_0000, 32'h2_0000, 0, 0, 0, 0));
    queue_pair(pair_of(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0));
    drain();

    // Random phases with differing idle and stall pressure.
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      idle_pct = pidle[ph % 4];
      stall_pct = pstall[ph % 4];
      for (int i = 0; i < 68; i++) queue_pair(random_pair());
      drain();
    end

    $display("checked %0d gamma results over 11 register settings", checked);
    $display("saturated to sill: %0d, zero: %0d", sat_seen, zero_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
